### hw/rtl/cnsw_pkg.sv
// Shared types, constants and helpers for the text-mode console writer.
// Used by cnsw_cell_store, cnsw_engine and text_mode_console_writer_core.
// No dependencies.
package cnsw_pkg;

    // Screen geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int TAB_STOP   = 8;
    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);

    // Field widths
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int POS_W  = 11;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = 16;
    localparam int IN_W   = 8;

    // Command codes
    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_SET   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;

    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [CHAR_W-1:0] char_code;
        logic [IN_W-1:0]   row_in;
        logic [IN_W-1:0]   col_in;
    } cmd_word_t;

    typedef struct packed {
        logic [ROW_W-1:0]  cursor_row_out;
        logic [COL_W-1:0]  cursor_col_out;
        logic [POS_W-1:0]  cursor_pos;
        logic [CELL_W-1:0] cell_value;
    } res_word_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [CELL_W-1:0] data;
    } cell_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } cell_rd_t;

    typedef struct packed {
        logic idle;
        logic done;
    } eng_status_t;

    typedef enum logic [6:0] {
        ST_FILL        = 7'b0000001,
        ST_IDLE        = 7'b0000010,
        ST_TAB         = 7'b0000100,
        ST_SCROLL      = 7'b0001000,
        ST_SCROLL_LAST = 7'b0010000,
        ST_READ        = 7'b0100000,
        ST_DONE        = 7'b1000000
    } state_t;

    // Linear cell index of a row/column pair
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        logic [ADDR_W-1:0] row_ext;
        row_ext = ADDR_W'(row);
        return ADDR_W'(row_ext * ADDR_W'(COLUMNS)) + ADDR_W'(col);
    endfunction

endpackage

### hw/rtl/cnsw_cell_store.sv
// Character cell memory: one write port, one read port, registered read data.
// Depends on cnsw_pkg.
module cnsw_cell_store (
    input  logic                              clk,
    input  cnsw_pkg::cell_wr_t                wr,
    input  cnsw_pkg::cell_rd_t                rd,
    output logic [cnsw_pkg::CELL_W-1:0]       rd_data
);

    logic [cnsw_pkg::CELL_W-1:0] cell_mem_reg [cnsw_pkg::CELL_COUNT];
    logic [cnsw_pkg::CELL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            cell_mem_reg[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= cell_mem_reg[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/cnsw_engine.sv
// Command sequencer: cursor state, fill/scroll/tab walks over the cell memory.
// Depends on cnsw_pkg; drives the ports of cnsw_cell_store.
module cnsw_engine (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    input  cnsw_pkg::cmd_word_t             cmd_word,
    input  logic [cnsw_pkg::ATTR_W-1:0]     attr,
    input  logic                            res_free,
    output cnsw_pkg::eng_status_t           status,
    output cnsw_pkg::res_word_t             result,
    output cnsw_pkg::cell_wr_t              cell_wr,
    output cnsw_pkg::cell_rd_t              cell_rd,
    input  logic [cnsw_pkg::CELL_W-1:0]     rd_data
);

    cnsw_pkg::state_t                  state_reg, state_next;
    logic [cnsw_pkg::ROW_W-1:0]        row_reg, row_next;
    logic [cnsw_pkg::COL_W-1:0]        col_reg, col_next;
    logic [cnsw_pkg::ADDR_W-1:0]       cnt_reg, cnt_next;
    logic [cnsw_pkg::ADDR_W-1:0]       wr_addr_reg, wr_addr_next;
    logic                              pend_reg, pend_next;
    logic                              init_reg, init_next;
    logic [cnsw_pkg::CELL_W-1:0]       cell_reg, cell_next;

    logic                              last_col;
    logic                              last_row;
    logic [cnsw_pkg::COL_W-1:0]        col_inc;
    logic [cnsw_pkg::ATTR_W-1:0]       fill_attr;
    logic [cnsw_pkg::ROW_W-1:0]        row_clamp;
    logic [cnsw_pkg::COL_W-1:0]        col_clamp;

    assign last_col  = (col_reg == cnsw_pkg::COL_W'(cnsw_pkg::COLUMNS - 1));
    assign last_row  = (row_reg == cnsw_pkg::ROW_W'(cnsw_pkg::ROWS - 1));
    assign col_inc   = col_reg + cnsw_pkg::COL_W'(1);
    assign fill_attr = init_reg ? cnsw_pkg::RESET_ATTR : attr;

    assign row_clamp = (cmd_word.row_in >= cnsw_pkg::IN_W'(cnsw_pkg::ROWS))
                     ? cnsw_pkg::ROW_W'(cnsw_pkg::ROWS - 1)
                     : cmd_word.row_in[cnsw_pkg::ROW_W-1:0];
    assign col_clamp = (cmd_word.col_in >= cnsw_pkg::IN_W'(cnsw_pkg::COLUMNS))
                     ? cnsw_pkg::COL_W'(cnsw_pkg::COLUMNS - 1)
                     : cmd_word.col_in[cnsw_pkg::COL_W-1:0];

    always_comb
    begin
        state_next   = state_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        cnt_next     = cnt_reg;
        wr_addr_next = wr_addr_reg;
        pend_next    = pend_reg;
        init_next    = init_reg;
        cell_next    = cell_reg;
        cell_wr      = '0;
        cell_rd      = '0;
        status       = '0;

        unique case (state_reg)
            cnsw_pkg::ST_FILL:
            begin
                cell_wr.en   = 1'b1;
                cell_wr.addr = cnt_reg;
                cell_wr.data = {fill_attr, cnsw_pkg::CH_SPACE};
                cnt_next     = cnt_reg + cnsw_pkg::ADDR_W'(1);
                if (cnt_reg == cnsw_pkg::ADDR_W'(cnsw_pkg::CELL_COUNT - 1))
                begin
                    init_next  = 1'b0;
                    state_next = init_reg ? cnsw_pkg::ST_IDLE : cnsw_pkg::ST_DONE;
                end
            end

            cnsw_pkg::ST_IDLE:
            begin
                status.idle = 1'b1;
                if (cmd_valid)
                begin
                    cell_next  = '0;
                    state_next = cnsw_pkg::ST_DONE;
                    unique case (cmd_word.cmd)
                        cnsw_pkg::CMD_PUT:
                        begin
                            priority if (cmd_word.char_code == cnsw_pkg::CH_NEWLINE)
                            begin
                                col_next = '0;
                                if (last_row)
                                begin
                                    cnt_next   = cnsw_pkg::ADDR_W'(cnsw_pkg::COLUMNS);
                                    pend_next  = 1'b0;
                                    state_next = cnsw_pkg::ST_SCROLL;
                                end
                                else
                                begin
                                    row_next = row_reg + cnsw_pkg::ROW_W'(1);
                                end
                            end
                            else if (cmd_word.char_code == cnsw_pkg::CH_TAB)
                            begin
                                state_next = cnsw_pkg::ST_TAB;
                            end
                            else if (cmd_word.char_code == cnsw_pkg::CH_BACKSPACE)
                            begin
                                // stay within the row
                                if (col_reg != '0)
                                begin
                                    col_next     = col_reg - cnsw_pkg::COL_W'(1);
                                    cell_wr.en   = 1'b1;
                                    cell_wr.addr = cnsw_pkg::cell_addr(row_reg,
                                                       col_reg - cnsw_pkg::COL_W'(1));
                                    cell_wr.data = {attr, cnsw_pkg::CH_SPACE};
                                end
                            end
                            else
                            begin
                                cell_wr.en   = 1'b1;
                                cell_wr.addr = cnsw_pkg::cell_addr(row_reg, col_reg);
                                cell_wr.data = {attr, cmd_word.char_code};
                                if (last_col)
                                begin
                                    col_next = '0;
                                    if (last_row)
                                    begin
                                        cnt_next   = cnsw_pkg::ADDR_W'(cnsw_pkg::COLUMNS);
                                        pend_next  = 1'b0;
                                        state_next = cnsw_pkg::ST_SCROLL;
                                    end
                                    else
                                    begin
                                        row_next = row_reg + cnsw_pkg::ROW_W'(1);
                                    end
                                end
                                else
                                begin
                                    col_next = col_inc;
                                end
                            end
                        end

                        cnsw_pkg::CMD_SET:
                        begin
                            row_next = row_clamp;
                            col_next = col_clamp;
                        end

                        cnsw_pkg::CMD_CLEAR:
                        begin
                            row_next   = '0;
                            col_next   = '0;
                            cnt_next   = '0;
                            state_next = cnsw_pkg::ST_FILL;
                        end

                        cnsw_pkg::CMD_READ:
                        begin
                            cell_rd.en   = 1'b1;
                            cell_rd.addr = cnsw_pkg::cell_addr(row_clamp, col_clamp);
                            state_next   = cnsw_pkg::ST_READ;
                        end

                        default:
                        begin
                            state_next = cnsw_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            cnsw_pkg::ST_TAB:
            begin
                // one space per cycle until the next tab stop
                cell_wr.en   = 1'b1;
                cell_wr.addr = cnsw_pkg::cell_addr(row_reg, col_reg);
                cell_wr.data = {attr, cnsw_pkg::CH_SPACE};
                if (last_col)
                begin
                    col_next = '0;
                    if (last_row)
                    begin
                        cnt_next   = cnsw_pkg::ADDR_W'(cnsw_pkg::COLUMNS);
                        pend_next  = 1'b0;
                        state_next = cnsw_pkg::ST_SCROLL;
                    end
                    else
                    begin
                        row_next   = row_reg + cnsw_pkg::ROW_W'(1);
                        state_next = cnsw_pkg::ST_DONE;
                    end
                end
                else
                begin
                    col_next = col_inc;
                    if ((col_inc % cnsw_pkg::COL_W'(cnsw_pkg::TAB_STOP)) == '0)
                    begin
                        state_next = cnsw_pkg::ST_DONE;
                    end
                end
            end

            cnsw_pkg::ST_SCROLL:
            begin
                // read one row ahead, write the word read last cycle
                cell_rd.en   = 1'b1;
                cell_rd.addr = cnt_reg;
                cell_wr.en   = pend_reg;
                cell_wr.addr = wr_addr_reg;
                cell_wr.data = rd_data;
                pend_next    = 1'b1;
                wr_addr_next = cnt_reg - cnsw_pkg::ADDR_W'(cnsw_pkg::COLUMNS);
                cnt_next     = cnt_reg + cnsw_pkg::ADDR_W'(1);
                if (cnt_reg == cnsw_pkg::ADDR_W'(cnsw_pkg::CELL_COUNT - 1))
                begin
                    state_next = cnsw_pkg::ST_SCROLL_LAST;
                end
            end

            cnsw_pkg::ST_SCROLL_LAST:
            begin
                cell_wr.en   = 1'b1;
                cell_wr.addr = wr_addr_reg;
                cell_wr.data = rd_data;
                pend_next    = 1'b0;
                cnt_next     = cnsw_pkg::ADDR_W'((cnsw_pkg::ROWS - 1) * cnsw_pkg::COLUMNS);
                state_next   = cnsw_pkg::ST_FILL;
            end

            cnsw_pkg::ST_READ:
            begin
                cell_next  = rd_data;
                state_next = cnsw_pkg::ST_DONE;
            end

            cnsw_pkg::ST_DONE:
            begin
                if (res_free)
                begin
                    status.done = 1'b1;
                    state_next  = cnsw_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = cnsw_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result.cursor_row_out = row_reg;
        result.cursor_col_out = col_reg;
        result.cursor_pos     = cnsw_pkg::POS_W'(cnsw_pkg::cell_addr(row_reg, col_reg));
        result.cell_value     = cell_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cnsw_pkg::ST_FILL;
            row_reg   <= '0;
            col_reg   <= '0;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            init_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            init_reg  <= init_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_addr_reg <= wr_addr_next;
        cell_reg    <= cell_next;
    end

endmodule

### hw/rtl/text_mode_console_writer_core.sv
// Text-mode console writer top level: attribute register, result register.
// Depends on cnsw_pkg, cnsw_engine and cnsw_cell_store.
//
// Console engine over an 80 x 25 screen of 16-bit cells (character in the
// low byte, attribute in the high byte), held in a single synchronous memory
// with one write and one read port. One command word goes in, one result word
// comes out: cursor row, column, linear position, and the cell read by a read
// command (zero otherwise). Right after reset a clearing pass writes spaces
// with attribute 0x0F to all 2000 cells, one per cycle; commands stall for
// the whole pass while attribute writes are taken as usual. Set cursor,
// plain characters, newline and backspace need no extra step; read cell
// waits on the registered memory read; a tab writes one space per cycle
// up to the next tab stop. Any wrap off the last row scrolls: a copy pass
// through the memory read/write ports moves rows 1 to 24 up one row, a
// drain step writes the last word read, and a fill pass blanks the last
// row. Clear fills every cell with a space in the current attribute. The
// memory sweep is one cell per cycle. The input stalls until the result
// word is loaded, so no new command is taken while one is in progress.
// A finished result waits in the output register; the next command is taken
// meanwhile and its result is held back until that register frees up.
module text_mode_console_writer_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  cnsw_pkg::cmd_word_t           cmd_word,
    output logic                          res_valid,
    input  logic                          res_stall,
    output cnsw_pkg::res_word_t           res_word,
    input  logic                          attr_wr_en,
    input  logic [cnsw_pkg::ATTR_W-1:0]   attr_wr_data
);

    logic [cnsw_pkg::ATTR_W-1:0]  attr_reg, attr_next;
    logic                         res_valid_reg, res_valid_next;
    cnsw_pkg::res_word_t          res_word_reg, res_word_next;

    cnsw_pkg::eng_status_t        status;
    cnsw_pkg::res_word_t          result;
    cnsw_pkg::cell_wr_t           cell_wr;
    cnsw_pkg::cell_rd_t           cell_rd;
    logic [cnsw_pkg::CELL_W-1:0]  rd_data;
    logic                         res_free;

    // Slot is free when empty or being drained this cycle
    assign res_free  = !res_valid_reg || !res_stall;

    // Take commands only while the sequencer sits idle
    assign cmd_stall = !status.idle;

    cnsw_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_word  (cmd_word),
        .attr      (attr_reg),
        .res_free  (res_free),
        .status    (status),
        .result    (result),
        .cell_wr   (cell_wr),
        .cell_rd   (cell_rd),
        .rd_data   (rd_data)
    );

    cnsw_cell_store u_store (
        .clk     (clk),
        .wr      (cell_wr),
        .rd      (cell_rd),
        .rd_data (rd_data)
    );

    always_comb
    begin
        // Latch a new attribute byte on write
        attr_next = attr_wr_en ? attr_wr_data : attr_reg;

        // Hold the result word until taken; load when the engine finishes
        res_valid_next = res_valid_reg && res_stall;
        res_word_next  = res_word_reg;
        if (status.done)
        begin
            res_valid_next = 1'b1;
            res_word_next  = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg      <= cnsw_pkg::RESET_ATTR;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            attr_reg      <= attr_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_word_reg <= res_word_next;
    end

    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

endmodule
